### src/fan_triangulate_vertex_dedup_unit_defines.svh
// assertion macros shared by the vertex dedup unit and its table
`ifndef FAN_TRIANGULATE_VERTEX_DEDUP_UNIT_DEFINES_SVH
`define FAN_TRIANGULATE_VERTEX_DEDUP_UNIT_DEFINES_SVH

// condition holds in the same cycle
`define FVD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition holds in the next cycle
`define FVD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/fvd_pkg.sv
// types, constants and compare functions for the vertex dedup unit
package fvd_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
   localparam int WORD_W      = 32;
   localparam int INDEX_W     = 10;

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      word_type pos_x;
      word_type pos_y;
      word_type pos_z;
      word_type tex_u;
      word_type tex_v;
   } vertex_type;

   typedef struct packed {
      word_type pos_x;
      word_type pos_y;
      word_type pos_z;
      word_type tex_u;
      word_type tex_v;
      logic     polygon_start;
      logic     object_start;
   } req_payload_type;

   typedef struct packed {
      logic [INDEX_W-1:0] vertex_index;
      logic               newly_added;
      logic               table_overflow;
      logic               triangle_end;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      FAN_IDLE,
      FAN_LOOKUP,
      FAN_EMIT
   } fan_state_type;

   // vertices seen in the current polygon, saturating once the fan is open
   typedef enum logic [1:0] {
      POS_NONE,
      POS_FIRST,
      POS_FAN
   } polygon_pos_type;

   typedef enum logic [1:0] {
      CORNER_FIRST,
      CORNER_PREVIOUS,
      CORNER_CURRENT
   } corner_type;

   typedef struct packed {
      logic       start;
      logic       clear;
      vertex_type key;
   } lookup_req_type;

   typedef struct packed {
      logic              done;
      logic [ADDR_W-1:0] index;
      logic              added;
      logic              overflow;
   } lookup_rsp_type;

   function automatic logic is_nan(input word_type w);
      return w[WORD_W-2:0] > 31'h7F80_0000;
   endfunction

   // ieee equality: signed zeros match, nan matches nothing
   function automatic logic float_equal(input word_type a, input word_type b);
      logic eq;
      eq = 1'b0;
      if (!is_nan(a) && !is_nan(b)) begin
         eq = (a == b) || ((a[WORD_W-2:0] | b[WORD_W-2:0]) == '0);
      end
      return eq;
   endfunction

   function automatic logic vertex_match(input vertex_type a, input vertex_type b);
      return float_equal(a.pos_x, b.pos_x) && float_equal(a.pos_y, b.pos_y) &&
             float_equal(a.pos_z, b.pos_z) && float_equal(a.tex_u, b.tex_u) &&
             float_equal(a.tex_v, b.tex_v);
   endfunction

endpackage

### src/fvd_channel_if.sv
// valid/ready channel carrying one payload per transaction
interface fvd_channel_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### src/fvd_table.sv
// vertex table memory with a sequential search and append engine
`include "fan_triangulate_vertex_dedup_unit_defines.svh"

module fvd_table (
   input  logic                    clock,
   input  logic                    reset,
   input  fvd_pkg::lookup_req_type lookup,
   output fvd_pkg::lookup_rsp_type result
);
   import fvd_pkg::*;

   vertex_type table_mem [TABLE_DEPTH];

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] ptr_ff, ptr_in;
   logic               scanning_ff, scanning_in;
   logic               rd_valid_ff, rd_valid_in;
   logic [ADDR_W-1:0]  rd_idx_ff, rd_idx_in;
   vertex_type         rd_data_ff;
   vertex_type         key_ff, key_in;

   logic hit;
   logic issue;
   logic finish;
   logic full;
   logic append;

   assign hit    = scanning_ff && rd_valid_ff && vertex_match(rd_data_ff, key_ff);
   assign issue  = scanning_ff && !hit && (ptr_ff < count_ff);
   assign finish = scanning_ff && (hit || (!rd_valid_ff && (ptr_ff >= count_ff)));
   assign full   = (count_ff == COUNT_W'(TABLE_DEPTH));
   assign append = finish && !hit && !full;

   always_comb begin
      count_in    = count_ff;
      ptr_in      = ptr_ff;
      scanning_in = scanning_ff;
      rd_valid_in = issue;
      rd_idx_in   = issue ? ptr_ff[ADDR_W-1:0] : rd_idx_ff;
      key_in      = key_ff;
      if (issue) begin
         ptr_in = ptr_ff + 1'b1;
      end
      if (finish) begin
         scanning_in = 1'b0;
         rd_valid_in = 1'b0;
      end
      if (append) begin
         count_in = count_ff + 1'b1;
      end
      if (lookup.start) begin
         scanning_in = 1'b1;
         rd_valid_in = 1'b0;
         ptr_in      = '0;
         key_in      = lookup.key;
      end
      if (lookup.clear) begin
         count_in = '0;
      end
   end

   always_comb begin
      result.done     = finish;
      result.added    = append;
      result.overflow = finish && !hit && full;
      if (hit) begin
         result.index = rd_idx_ff;
      end else if (full) begin
         result.index = '0;
      end else begin
         result.index = count_ff[ADDR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         scanning_ff <= 1'b0;
         rd_valid_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         scanning_ff <= scanning_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff    <= ptr_in;
      rd_idx_ff <= rd_idx_in;
      key_ff    <= key_in;
   end

   // one read and one write port, read data registered
   always_ff @(posedge clock) begin
      if (append) begin
         table_mem[count_ff[ADDR_W-1:0]] <= key_ff;
      end
      if (issue) begin
         rd_data_ff <= table_mem[ptr_ff[ADDR_W-1:0]];
      end
   end

   `FVD_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= COUNT_W'(TABLE_DEPTH), "entry count past depth")
   `FVD_ASSERT_NOW(a_read_in_scan, rd_valid_ff, scanning_ff, "read data outside a search")
   `FVD_ASSERT_NEXT(a_append_grows, append && !lookup.clear, count_ff == $past(count_ff) + 1'b1, "append did not grow the table")
   `FVD_ASSERT_NOW(a_start_idle, lookup.start, !scanning_ff, "search started while busy")

endmodule

### src/fan_triangulate_vertex_dedup_unit.sv
// fan triangulation with vertex deduplication: top level
//
// req_channel carries one polygon vertex per transaction (five ieee words,
// polygon_start, object_start). From the third vertex of a polygon on, the
// unit emits the triangle (first, previous, current) on rsp_channel as three
// transactions, one per corner, triangle_end set on the last one.
// object_start empties the vertex table before the vertex is handled.
//
// Each corner is looked up by a linear search of the vertex table memory,
// one entry read per cycle through its single registered read port, and
// appended on a miss while the table is not full. A miss reads every entry,
// a hit ends the search at the matching entry; the result then passes
// through the output register. The first and second vertex of a polygon
// are only stored, with no search. One vertex is handled at a time: req
// ready is high only while idle.
//
// Reset empties the table and the polygon state at once, no clearing pass.
// A stalled receiver holds the corner in the output register and the search
// of the next corner waits until it is taken.
`include "fan_triangulate_vertex_dedup_unit_defines.svh"

module fan_triangulate_vertex_dedup_unit (
   input logic          clock,
   input logic          reset,
   fvd_channel_if.sink   req_channel,
   fvd_channel_if.source rsp_channel
);
   import fvd_pkg::*;

   fan_state_type   state_ff, state_in;
   polygon_pos_type pos_ff, pos_in;
   corner_type      corner_ff, corner_in;
   vertex_type      first_ff, first_in;
   vertex_type      prev_ff, prev_in;
   vertex_type      cur_ff, cur_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   lookup_req_type  lookup;
   lookup_rsp_type  result;

   req_payload_type req_data;
   vertex_type      req_vertex;
   polygon_pos_type pos_eff;
   logic            req_accept;
   logic            rsp_accept;

   assign req_data   = req_channel.payload;
   assign req_vertex = '{pos_x: req_data.pos_x, pos_y: req_data.pos_y,
                         pos_z: req_data.pos_z, tex_u: req_data.tex_u,
                         tex_v: req_data.tex_v};
   assign req_accept = req_channel.valid && req_channel.ready;
   assign rsp_accept = rsp_valid_ff && rsp_channel.ready;
   assign pos_eff    = (req_data.polygon_start || req_data.object_start) ? POS_NONE : pos_ff;

   assign req_channel.ready   = (state_ff == FAN_IDLE);
   assign rsp_channel.valid   = rsp_valid_ff;
   assign rsp_channel.payload = rsp_payload_ff;

   fvd_table u_table (
      .clock  (clock),
      .reset  (reset),
      .lookup (lookup),
      .result (result)
   );

   always_comb begin
      state_in       = state_ff;
      pos_in         = pos_ff;
      corner_in      = corner_ff;
      first_in       = first_ff;
      prev_in        = prev_ff;
      cur_in         = cur_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      lookup.start   = 1'b0;
      lookup.clear   = 1'b0;
      lookup.key     = first_ff;
      case (state_ff)
         FAN_IDLE: begin
            if (req_accept) begin
               lookup.clear = req_data.object_start;
               case (pos_eff)
                  POS_NONE: begin
                     first_in = req_vertex;
                     pos_in   = POS_FIRST;
                  end
                  POS_FIRST: begin
                     prev_in = req_vertex;
                     pos_in  = POS_FAN;
                  end
                  default: begin
                     cur_in       = req_vertex;
                     corner_in    = CORNER_FIRST;
                     lookup.start = 1'b1;
                     lookup.key   = first_ff;
                     state_in     = FAN_LOOKUP;
                  end
               endcase
            end
         end
         FAN_LOOKUP: begin
            if (result.done) begin
               rsp_valid_in                  = 1'b1;
               rsp_payload_in.vertex_index   = INDEX_W'(result.index);
               rsp_payload_in.newly_added    = result.added;
               rsp_payload_in.table_overflow = result.overflow;
               rsp_payload_in.triangle_end   = (corner_ff == CORNER_CURRENT);
               state_in                      = FAN_EMIT;
            end
         end
         FAN_EMIT: begin
            if (rsp_accept) begin
               rsp_valid_in = 1'b0;
               case (corner_ff)
                  CORNER_FIRST: begin
                     corner_in    = CORNER_PREVIOUS;
                     lookup.start = 1'b1;
                     lookup.key   = prev_ff;
                     state_in     = FAN_LOOKUP;
                  end
                  CORNER_PREVIOUS: begin
                     corner_in    = CORNER_CURRENT;
                     lookup.start = 1'b1;
                     lookup.key   = cur_ff;
                     state_in     = FAN_LOOKUP;
                  end
                  default: begin
                     // fan moves on: current vertex becomes the previous one
                     prev_in  = cur_ff;
                     state_in = FAN_IDLE;
                  end
               endcase
            end
         end
         default: begin
            state_in = FAN_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FAN_IDLE;
         pos_ff       <= POS_NONE;
         corner_ff    <= CORNER_FIRST;
         rsp_valid_ff <= 1'b0;
         first_ff     <= '0;
         prev_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         corner_ff    <= corner_in;
         rsp_valid_ff <= rsp_valid_in;
         first_ff     <= first_in;
         prev_ff      <= prev_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff         <= cur_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   `FVD_ASSERT_NOW(a_valid_in_emit, rsp_valid_ff, state_ff == FAN_EMIT, "result shown outside emit")
   `FVD_ASSERT_NOW(a_done_in_lookup, result.done, state_ff == FAN_LOOKUP, "search finished unexpectedly")
   `FVD_ASSERT_NOW(a_start_in_fan, lookup.start, pos_ff == POS_FAN || state_ff == FAN_IDLE, "lookup without an open fan")
   `FVD_ASSERT_NEXT(a_end_to_idle, rsp_accept && rsp_payload_ff.triangle_end, req_channel.ready, "not idle after last corner")

endmodule
